### hdl/tmba_pkg.sv
package tmba_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 10;
    localparam int MV_W       = 12;
    localparam int VREF_W     = 12;
    localparam int GAIN_W     = 3;
    localparam int OFFSET_W   = 11;
    localparam int BATT_W     = 16;
    localparam int SUM_W      = 19;
    localparam int COUNT_W    = 7;
    localparam int SCALE_W    = SAMPLE_W + VREF_W;
    localparam int GPROD_W    = MV_W + GAIN_W;
    localparam int BSUM_W     = 17;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_VREF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    // Register reset values.
    localparam logic [VREF_W-1:0]          VREF_RESET   = 12'd2560;
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 3'd2;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 11'sd100;

    // Window reset values and scale divisor.
    localparam logic [MV_W-1:0] MIN_RESET = 12'hFFF;
    localparam int              SCALE_SHIFT = 10;

    // Battery output limits.
    localparam logic signed [BSUM_W-1:0] BATT_MAX = 17'sd17403;
    localparam logic signed [BSUM_W-1:0] BATT_MIN = -17'sd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACC,
        ST_MEAN,
        ST_BATT,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scale;
        logic accumulate;
        logic finish_mean;
        logic finish_batt;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_sample;
    } status_t;

endpackage

### hdl/trimmed_mean_battery_adc.sv
// Trimmed-mean battery monitor. Each 10-bit ADC beat on the s_ side is scaled to
// millivolts as sample * vref_mv / 1024 and folded into a window of 2^SHIFT + 2
// samples; on the last sample of a window the largest and smallest values are
// dropped, the rest is divided by 2^SHIFT, and one m_ beat carries that mean
// with the battery voltage mean * divider_gain + offset_mv, saturated to
// -1024 .. 17403. A sample passes the accept, scaling multiply and accumulate
// steps before the next is accepted; the last sample of a window then passes the
// mean, battery and output load stages, the load waiting while the previous result
// is held in the output register. The user must write the registers through
// cfg_wr_en, cfg_index and cfg_data only while the block is idle; it does not enforce this.
module trimmed_mean_battery_adc #(
    parameter int SHIFT = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tmba_pkg::S_TDATA_W-1:0]      s_tdata,   // [9:0] adc_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tmba_pkg::M_TDATA_W-1:0]      m_tdata,   // [11:0] mean_mv, [27:12] battery_mv
    input  logic                                cfg_wr_en,
    input  logic [tmba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmba_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tmba_pkg::cmd_t              cmd;
    tmba_pkg::status_t           status;
    logic [tmba_pkg::MV_W-1:0]   mean_mv;
    logic [tmba_pkg::BATT_W-1:0] battery_mv;

    tmba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    tmba_dpath #(
        .SHIFT (SHIFT)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adc_sample (s_tdata[tmba_pkg::SAMPLE_W-1:0]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .mean_mv    (mean_mv),
        .battery_mv (battery_mv)
    );

    // Output beat packing, padded to whole bytes.
    assign m_tdata = {{(tmba_pkg::M_TDATA_W - tmba_pkg::BATT_W - tmba_pkg::MV_W){1'b0}},
                      battery_mv, mean_mv};

    // One sample at a time: no second beat straight after an accepted one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register loaded while a result is pending");

    // Scaling follows an accepted beat directly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scale |-> $past(s_tvalid && s_tready))
        else $error("scaling without an accepted sample");

    // The mean is taken only straight after the window's last sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish_mean |-> $past(cmd.accumulate && status.last_sample))
        else $error("mean computed outside the end of a window");

endmodule

### hdl/tmba_ctrl.sv
module tmba_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             m_tready,
    input  tmba_pkg::status_t status,
    output logic             s_tready,
    output logic             m_tvalid,
    output tmba_pkg::cmd_t   cmd
);

    tmba_pkg::state_t state_reg;
    tmba_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmba_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            tmba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = tmba_pkg::ST_SCALE;
                end
            end
            tmba_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = tmba_pkg::ST_ACC;
            end
            tmba_pkg::ST_ACC: begin
                cmd.accumulate = 1'b1;
                state_next     = status.last_sample ? tmba_pkg::ST_MEAN : tmba_pkg::ST_IDLE;
            end
            tmba_pkg::ST_MEAN: begin
                cmd.finish_mean = 1'b1;
                state_next      = tmba_pkg::ST_BATT;
            end
            tmba_pkg::ST_BATT: begin
                cmd.finish_batt = 1'b1;
                state_next      = tmba_pkg::ST_OUT;
            end
            tmba_pkg::ST_OUT: begin
                // Wait until the output register is free.
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = tmba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tmba_pkg::ST_IDLE;
            end
        endcase
    end

    // The output beat stays valid until taken.
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### hdl/tmba_dpath.sv
module tmba_dpath #(
    parameter int SHIFT = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tmba_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic                              cfg_wr_en,
    input  logic [tmba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tmba_pkg::cmd_t                    cmd,
    output tmba_pkg::status_t                 status,
    output logic [tmba_pkg::MV_W-1:0]         mean_mv,
    output logic [tmba_pkg::BATT_W-1:0]       battery_mv
);

    localparam logic [tmba_pkg::COUNT_W-1:0] WINDOW_LEN =
        tmba_pkg::COUNT_W'((1 << SHIFT) + 2);

    logic [tmba_pkg::VREF_W-1:0]          vref_reg;
    logic [tmba_pkg::GAIN_W-1:0]          gain_reg;
    logic signed [tmba_pkg::OFFSET_W-1:0] offset_reg;

    logic [tmba_pkg::SAMPLE_W-1:0] sample_reg;
    logic [tmba_pkg::MV_W-1:0]     scaled_reg;
    logic [tmba_pkg::COUNT_W-1:0]  count_reg;
    logic [tmba_pkg::COUNT_W-1:0]  count_next;
    logic [tmba_pkg::SUM_W-1:0]    sum_reg;
    logic [tmba_pkg::MV_W-1:0]     max_reg;
    logic [tmba_pkg::MV_W-1:0]     min_reg;
    logic [tmba_pkg::MV_W-1:0]     mean_reg;
    logic [tmba_pkg::BATT_W-1:0]   batt_reg;
    logic [tmba_pkg::MV_W-1:0]     out_mean_reg;
    logic [tmba_pkg::BATT_W-1:0]   out_batt_reg;

    logic [tmba_pkg::SCALE_W-1:0]        scale_prod;
    logic [tmba_pkg::SUM_W-1:0]          trimmed;
    logic [tmba_pkg::GPROD_W-1:0]        gain_prod;
    logic signed [tmba_pkg::BSUM_W-1:0]  batt_sum;
    logic signed [tmba_pkg::BSUM_W-1:0]  batt_sat;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg   <= tmba_pkg::VREF_RESET;
            gain_reg   <= tmba_pkg::GAIN_RESET;
            offset_reg <= tmba_pkg::OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tmba_pkg::CFG_VREF:   vref_reg   <= cfg_data;
                tmba_pkg::CFG_GAIN:   gain_reg   <= cfg_data[tmba_pkg::GAIN_W-1:0];
                tmba_pkg::CFG_OFFSET: offset_reg <= $signed(cfg_data[tmba_pkg::OFFSET_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Scaling to millivolts: one multiply, truncated by the ADC full scale.
    assign scale_prod = tmba_pkg::SCALE_W'(sample_reg) * tmba_pkg::SCALE_W'(vref_reg);

    // Sum less the largest and smallest sample; never negative over a full window.
    assign trimmed = sum_reg - tmba_pkg::SUM_W'(max_reg) - tmba_pkg::SUM_W'(min_reg);

    // Battery voltage before saturation.
    assign gain_prod = tmba_pkg::GPROD_W'(mean_reg) * tmba_pkg::GPROD_W'(gain_reg);
    assign batt_sum  = $signed({2'b00, gain_prod})
                     + $signed({{(tmba_pkg::BSUM_W - tmba_pkg::OFFSET_W){offset_reg[tmba_pkg::OFFSET_W-1]}},
                                offset_reg});

    always_comb begin
        if (batt_sum > tmba_pkg::BATT_MAX) begin
            batt_sat = tmba_pkg::BATT_MAX;
        end else if (batt_sum < tmba_pkg::BATT_MIN) begin
            batt_sat = tmba_pkg::BATT_MIN;
        end else begin
            batt_sat = batt_sum;
        end
    end

    assign count_next         = count_reg + 1'b1;
    assign status.last_sample = (count_next == WINDOW_LEN);

    // Window state: accumulate each sample, clear once the mean is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= tmba_pkg::MIN_RESET;
        end else if (cmd.accumulate) begin
            count_reg <= count_next;
            sum_reg   <= sum_reg + tmba_pkg::SUM_W'(scaled_reg);
            if (scaled_reg > max_reg) begin
                max_reg <= scaled_reg;
            end
            if (scaled_reg < min_reg) begin
                min_reg <= scaled_reg;
            end
        end else if (cmd.finish_mean) begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= tmba_pkg::MIN_RESET;
        end
    end

    // Payload registers along the sample path.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= adc_sample;
        end
        if (cmd.scale) begin
            scaled_reg <= scale_prod[tmba_pkg::SCALE_SHIFT +: tmba_pkg::MV_W];
        end
        if (cmd.finish_mean) begin
            mean_reg <= trimmed[SHIFT +: tmba_pkg::MV_W];
        end
        if (cmd.finish_batt) begin
            batt_reg <= batt_sat[tmba_pkg::BATT_W-1:0];
        end
        if (cmd.load_out) begin
            out_mean_reg <= mean_reg;
            out_batt_reg <= batt_reg;
        end
    end

    assign mean_mv    = out_mean_reg;
    assign battery_mv = out_batt_reg;

endmodule
